@@ sv/open_addressing_hash_table_assert.svh @@
// Assertion macros shared by the hash table modules.
`ifndef OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define OAHT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("oaht assertion failed");
`define OAHT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("oaht assertion failed");
`else
`define OAHT_ASSERT(label, clk, rstn, prop)
`define OAHT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ sv/oaht_pkg.sv @@
// Shared types and constants of the open addressing hash table.
package oaht_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int DATA_WIDTH_DEF  = 32;

    // key bits folded into the slot remainder per cycle
    localparam int HASH_BITS_PER_STEP = 4;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RESERVED  = 3'd4;

    typedef struct packed {
        logic                load_item;
        logic                hash_step;
        logic                fetch;
        logic                probe_next;
        logic                clear_write;
        logic                write_insert;
        logic                write_delete;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
        logic                out_data_sel;
    } oaht_cmd_t;

    typedef struct packed {
        logic             clear_last;
        logic             hash_last;
        logic             key_reserved;
        logic [CMD_W-1:0] command;
        logic             slot_empty;
        logic             slot_deleted;
        logic             key_hit;
        logic             probe_last;
    } oaht_stat_t;

endpackage

@@ sv/open_addressing_hash_table.sv @@
// Top level of the linear probing hash table: controller and datapath.
//
// Requests (s_command, s_key, s_data_in) enter on a valid/ready channel; every
// request gives one result (m_status, m_data_out) on a valid/ready channel.
// Commands: find, insert, delete. Keys 0 and 1 mark empty and deleted slots and
// are rejected with the reserved status. Probing starts at key mod TABLE_DEPTH.
// The slot hash folds 4 key bits a cycle, msb first. Each probed slot takes one
// read on the key store read port; 1..TABLE_DEPTH slots are probed.
// Reserved keys and the unused command skip the hash and the probe.
// One request is in flight at a time; s_ready is high only when it is idle.
// After reset the key store is swept to empty, one slot a cycle;
// s_ready stays low meanwhile.
// A stalled result sits in the output register; the block finishes the next
// request and holds it until the output register frees up.
module open_addressing_hash_table #(
    parameter int TABLE_DEPTH = oaht_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = oaht_pkg::KEY_WIDTH_DEF,
    parameter int DATA_WIDTH  = oaht_pkg::DATA_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [oaht_pkg::CMD_W-1:0]    s_command,
    input  logic [KEY_WIDTH-1:0]          s_key,
    input  logic [DATA_WIDTH-1:0]         s_data_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [oaht_pkg::STATUS_W-1:0] m_status,
    output logic [DATA_WIDTH-1:0]         m_data_out
);
    import oaht_pkg::*;

    oaht_cmd_t  cmd;
    oaht_stat_t stat;

    oaht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    oaht_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_command  (s_command),
        .s_key      (s_key),
        .s_data_in  (s_data_in),
        .cmd        (cmd),
        .stat       (stat),
        .m_status   (m_status),
        .m_data_out (m_data_out)
    );

endmodule

@@ sv/oaht_dp.sv @@
// Datapath: request registers, slot hash unit, key and data stores, result register.
`include "open_addressing_hash_table_assert.svh"

module oaht_dp #(
    parameter int TABLE_DEPTH = oaht_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = oaht_pkg::KEY_WIDTH_DEF,
    parameter int DATA_WIDTH  = oaht_pkg::DATA_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [oaht_pkg::CMD_W-1:0]    s_command,
    input  logic [KEY_WIDTH-1:0]          s_key,
    input  logic [DATA_WIDTH-1:0]         s_data_in,
    input  oaht_pkg::oaht_cmd_t           cmd,
    output oaht_pkg::oaht_stat_t          stat,
    output logic [oaht_pkg::STATUS_W-1:0] m_status,
    output logic [DATA_WIDTH-1:0]         m_data_out
);
    import oaht_pkg::*;

    localparam int IDX_W      = $clog2(TABLE_DEPTH);
    localparam int HASH_STEPS = (KEY_WIDTH + HASH_BITS_PER_STEP - 1) / HASH_BITS_PER_STEP;
    localparam int HASH_W     = HASH_STEPS * HASH_BITS_PER_STEP;
    localparam int STEP_W     = (HASH_STEPS > 1) ? $clog2(HASH_STEPS) : 1;

    localparam logic [IDX_W:0]      DepthExt   = (IDX_W + 1)'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0]    LastSlot   = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [STEP_W-1:0]   LastStep   = STEP_W'(HASH_STEPS - 1);
    localparam logic [KEY_WIDTH-1:0] KeyEmpty   = '0;
    localparam logic [KEY_WIDTH-1:0] KeyDeleted = KEY_WIDTH'(1);

    // request
    logic [CMD_W-1:0]      command_reg;
    logic [KEY_WIDTH-1:0]  key_reg;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [HASH_W-1:0]     hash_sr_reg;

    // probe control
    logic [STEP_W-1:0] step_cnt_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic [IDX_W-1:0]  chk_slot_reg;
    logic [IDX_W-1:0]  probe_cnt_reg;
    logic [IDX_W-1:0]  clr_idx_reg;

    // stores and read data
    logic [KEY_WIDTH-1:0]  key_store_reg  [TABLE_DEPTH];
    logic [DATA_WIDTH-1:0] data_store_reg [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0]  rd_key_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // result
    logic [STATUS_W-1:0]   out_status_reg;
    logic [DATA_WIDTH-1:0] out_data_reg;

    logic [IDX_W-1:0]     hash_rem;
    logic [IDX_W:0]       hash_trial;
    logic [IDX_W-1:0]     slot_inc;
    logic                 rd_en;
    logic                 key_we;
    logic [IDX_W-1:0]     key_waddr;
    logic [KEY_WIDTH-1:0] key_wdata;

    // remainder of the key by the table depth, a few bits per cycle, msb first
    always_comb begin
        hash_rem   = slot_reg;
        hash_trial = '0;
        for (int i = 0; i < HASH_BITS_PER_STEP; i++) begin
            hash_trial = {hash_rem, hash_sr_reg[HASH_W-1-i]};
            if (hash_trial >= DepthExt) begin
                hash_rem = IDX_W'(hash_trial - DepthExt);
            end else begin
                hash_rem = hash_trial[IDX_W-1:0];
            end
        end
    end

    assign slot_inc = (slot_reg == LastSlot) ? '0 : slot_reg + 1'b1;
    assign rd_en    = cmd.fetch | cmd.probe_next;

    always_comb begin
        key_we    = cmd.clear_write | cmd.write_insert | cmd.write_delete;
        key_waddr = cmd.clear_write ? clr_idx_reg : chk_slot_reg;
        if (cmd.write_insert) begin
            key_wdata = key_reg;
        end else if (cmd.write_delete) begin
            key_wdata = KeyDeleted;
        end else begin
            key_wdata = KeyEmpty;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_cnt_reg  <= '0;
            probe_cnt_reg <= '0;
            clr_idx_reg   <= '0;
        end else begin
            if (cmd.load_item) begin
                step_cnt_reg <= '0;
            end else if (cmd.hash_step) begin
                step_cnt_reg <= step_cnt_reg + 1'b1;
            end
            if (cmd.fetch) begin
                probe_cnt_reg <= '0;
            end else if (cmd.probe_next) begin
                probe_cnt_reg <= probe_cnt_reg + 1'b1;
            end
            if (cmd.clear_write) begin
                clr_idx_reg <= (clr_idx_reg == LastSlot) ? '0 : clr_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            command_reg <= s_command;
            key_reg     <= s_key;
            data_reg    <= s_data_in;
            hash_sr_reg <= HASH_W'(s_key);
            slot_reg    <= '0;
        end else if (cmd.hash_step) begin
            hash_sr_reg <= hash_sr_reg << HASH_BITS_PER_STEP;
            slot_reg    <= hash_rem;
        end else if (rd_en) begin
            slot_reg <= slot_inc;
        end
        if (rd_en) begin
            chk_slot_reg <= slot_reg;
        end
        if (cmd.out_load) begin
            out_status_reg <= cmd.out_status;
            out_data_reg   <= cmd.out_data_sel ? rd_data_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_store_reg[key_waddr] <= key_wdata;
        end
        if (rd_en) begin
            rd_key_reg <= key_store_reg[slot_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_insert) begin
            data_store_reg[chk_slot_reg] <= data_reg;
        end
        if (rd_en) begin
            rd_data_reg <= data_store_reg[slot_reg];
        end
    end

    always_comb begin
        stat              = '0;
        stat.clear_last   = (clr_idx_reg == LastSlot);
        stat.hash_last    = (step_cnt_reg == LastStep);
        stat.key_reserved = (key_reg == KeyEmpty) || (key_reg == KeyDeleted);
        stat.command      = command_reg;
        stat.slot_empty   = (rd_key_reg == KeyEmpty);
        stat.slot_deleted = (rd_key_reg == KeyDeleted);
        stat.key_hit      = (rd_key_reg == key_reg);
        stat.probe_last   = (probe_cnt_reg == LastSlot);
    end

    assign m_status   = out_status_reg;
    assign m_data_out = out_data_reg;

    `OAHT_ASSERT(a_clr_idx_range, aclk, aresetn, {1'b0, clr_idx_reg} < DepthExt)
    `OAHT_ASSERT(a_probe_slot_range, aclk, aresetn, !rd_en || ({1'b0, slot_reg} < DepthExt))
    `OAHT_ASSERT_NEXT(a_chk_tracks_read, aclk, aresetn, rd_en, chk_slot_reg == $past(slot_reg))

endmodule

@@ sv/oaht_ctrl.sv @@
// Controller: table clear after reset, request sequencing, probe decisions, result handshake.
`include "open_addressing_hash_table_assert.svh"

module oaht_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  oaht_pkg::oaht_stat_t stat,
    output oaht_pkg::oaht_cmd_t  cmd
);
    import oaht_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_FETCH,
        S_PROBE,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                res_sel_reg, res_sel_next;
    logic                out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        cmd             = '0;
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_sel_next    = res_sel_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_write = 1'b1;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_HASH;
                end
            end
            S_HASH: begin
                res_sel_next = 1'b0;
                if (stat.key_reserved) begin
                    res_status_next = ST_RESERVED;
                    state_next      = S_DONE;
                end else if (stat.command == CMD_UNUSED) begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_DONE;
                end else begin
                    cmd.hash_step = 1'b1;
                    if (stat.hash_last) begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = S_PROBE;
            end
            S_PROBE: begin
                state_next = S_DONE;
                if (stat.command == CMD_INSERT) begin
                    if (stat.slot_empty || stat.slot_deleted) begin
                        cmd.write_insert = 1'b1;
                        res_status_next  = ST_OK;
                    end else if (stat.key_hit) begin
                        res_status_next = ST_DUPLICATE;
                    end else if (stat.probe_last) begin
                        res_status_next = ST_FULL;
                    end else begin
                        cmd.probe_next = 1'b1;
                        state_next     = S_PROBE;
                    end
                end else begin
                    // find and delete skip deleted slots, stop at an empty one
                    if (stat.slot_empty) begin
                        res_status_next = ST_NOT_FOUND;
                    end else if (stat.key_hit) begin
                        res_status_next = ST_OK;
                        if (stat.command == CMD_FIND) begin
                            res_sel_next = 1'b1;
                        end else begin
                            cmd.write_delete = 1'b1;
                        end
                    end else if (stat.probe_last) begin
                        res_status_next = ST_NOT_FOUND;
                    end else begin
                        cmd.probe_next = 1'b1;
                        state_next     = S_PROBE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load     = 1'b1;
                    cmd.out_status   = res_status_reg;
                    cmd.out_data_sel = res_sel_reg;
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            m_valid_reg    <= 1'b0;
            res_status_reg <= ST_OK;
            res_sel_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            res_status_reg <= res_status_next;
            res_sel_reg    <= res_sel_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    `OAHT_ASSERT(a_one_writer, aclk, aresetn,
        $onehot0({cmd.clear_write, cmd.write_insert, cmd.write_delete}))
    `OAHT_ASSERT(a_insert_free_slot, aclk, aresetn,
        !cmd.write_insert || stat.slot_empty || stat.slot_deleted)
    `OAHT_ASSERT(a_no_result_overwrite, aclk, aresetn, !cmd.out_load || out_free)

endmodule

@@ bench/tb_open_addressing_hash_table.sv @@
// Self-checking testbench for the linear probing hash table: directed rows, then random traffic.
`timescale 1ns / 100ps

module tb_open_addressing_hash_table;
    import oaht_pkg::*;

    localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
    localparam int KEY_WIDTH   = KEY_WIDTH_DEF;
    localparam int DATA_WIDTH  = DATA_WIDTH_DEF;

    localparam logic [KEY_WIDTH-1:0] KEY_EMPTY   = '0;
    localparam logic [KEY_WIDTH-1:0] KEY_DELETED = KEY_WIDTH'(1);

    localparam int RANDOM_REQUESTS = 1700;
    localparam int POOL_SIZE       = 96;
    localparam int IDLE_LIMIT      = 4000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int HOLD_CYCLES     = 600;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [DATA_WIDTH-1:0] data;
    } result_t;

    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        logic [KEY_WIDTH-1:0]  key;
        logic [DATA_WIDTH-1:0] data;
        logic                  typed;
        logic [STATUS_W-1:0]   status;
        logic [DATA_WIDTH-1:0] rdata;
    } row_t;

    localparam int NUM_ROWS = 22;

    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_command  = CMD_FIND;
    logic [KEY_WIDTH-1:0]  s_key      = '0;
    logic [DATA_WIDTH-1:0] s_data_in  = '0;
    logic                  m_valid;
    logic                  m_ready    = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [DATA_WIDTH-1:0] m_data_out;

    // predictor copy of the table
    logic [KEY_WIDTH-1:0]  model_keys [TABLE_DEPTH];
    logic [DATA_WIDTH-1:0] model_data [TABLE_DEPTH];

    result_t               pending_results [$];
    logic [KEY_WIDTH-1:0]  key_pool [POOL_SIZE];
    int                    mismatch_count = 0;
    int                    requests_sent  = 0;
    int                    burst_left     = 0;
    int                    idle_cycles    = 0;
    int                    rx_cycle       = 0;
    int                    rx_mode        = 0;
    int                    hold_left      = 0;

    row_t directed_rows [NUM_ROWS] = '{
        '{CMD_FIND,   32'h0000_0000, 32'h0000_0000, 1'b1, ST_RESERVED,  32'h0},
        '{CMD_INSERT, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, ST_RESERVED,  32'h0},
        '{CMD_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_RESERVED,  32'h0},
        '{CMD_UNUSED, 32'h0000_0001, 32'h0000_0000, 1'b1, ST_RESERVED,  32'h0},
        '{CMD_UNUSED, 32'h0000_0005, 32'h1234_5678, 1'b1, ST_NOT_FOUND, 32'h0},
        '{CMD_FIND,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 32'h0},
        '{CMD_DELETE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 32'h0},
        '{CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_OK,        32'h0},
        '{CMD_FIND,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_OK,        32'hFFFF_FFFF},
        '{CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_DUPLICATE, 32'h0},
        '{CMD_INSERT, 32'h0000_0002, 32'h0000_0000, 1'b1, ST_OK,        32'h0},
        '{CMD_INSERT, 32'h0000_0042, 32'hA5A5_A5A5, 1'b0, ST_OK,        32'h0},
        '{CMD_INSERT, 32'h0000_0082, 32'h5A5A_5A5A, 1'b0, ST_OK,        32'h0},
        '{CMD_DELETE, 32'h0000_0042, 32'h0000_0000, 1'b0, ST_OK,        32'h0},
        '{CMD_FIND,   32'h0000_0082, 32'h0000_0000, 1'b0, ST_OK,        32'h0},
        '{CMD_FIND,   32'h0000_0042, 32'h0000_0000, 1'b0, ST_OK,        32'h0},
        '{CMD_INSERT, 32'h0000_00C2, 32'h1234_5678, 1'b0, ST_OK,        32'h0},
        '{CMD_FIND,   32'h0000_0002, 32'hFFFF_FFFF, 1'b0, ST_OK,        32'h0},
        '{CMD_INSERT, 32'h8000_0003, 32'h0000_0000, 1'b0, ST_OK,        32'h0},
        '{CMD_DELETE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_OK,        32'h0},
        '{CMD_FIND,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 32'h0},
        '{CMD_FIND,   32'h7FFF_FFFE, 32'hFFFF_FFFF, 1'b0, ST_OK,        32'h0}
    };

    open_addressing_hash_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_key      (s_key),
        .s_data_in  (s_data_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_data_out (m_data_out)
    );

    always #5 aclk = ~aclk;

    // Applies one request to the predictor table and returns its result.
    function automatic result_t probe_table(input logic [CMD_W-1:0] cmd,
                                            input logic [KEY_WIDTH-1:0] key,
                                            input logic [DATA_WIDTH-1:0] data);
        result_t res;
        int      slot;
        int      n;
        bit      done;
        res.status = ST_NOT_FOUND;
        res.data   = '0;
        done       = 1'b0;
        if (key == KEY_EMPTY || key == KEY_DELETED) begin
            res.status = ST_RESERVED;
        end else if (cmd != CMD_UNUSED) begin
            slot = int'(key % TABLE_DEPTH);
            if (cmd == CMD_INSERT) begin
                res.status = ST_FULL;
            end
            for (n = 0; n < TABLE_DEPTH && !done; n++) begin
                if (cmd == CMD_INSERT) begin
                    if (model_keys[slot] == KEY_EMPTY || model_keys[slot] == KEY_DELETED) begin
                        model_keys[slot] = key;
                        model_data[slot] = data;
                        res.status = ST_OK;
                        done = 1'b1;
                    end else if (model_keys[slot] == key) begin
                        res.status = ST_DUPLICATE;
                        done = 1'b1;
                    end
                end else if (model_keys[slot] == KEY_EMPTY) begin
                    done = 1'b1;
                end else if (model_keys[slot] == key) begin
                    res.status = ST_OK;
                    if (cmd == CMD_FIND) begin
                        res.data = model_data[slot];
                    end else begin
                        model_keys[slot] = KEY_DELETED;
                    end
                    done = 1'b1;
                end
                slot = (slot + 1 == TABLE_DEPTH) ? 0 : slot + 1;
            end
        end
        return res;
    endfunction

    // Offers one request, waits for it to be taken, records the expected
    // result and then either keeps the burst going or idles for a while.
    task automatic offer(input logic [CMD_W-1:0] cmd, input logic [KEY_WIDTH-1:0] key,
                         input logic [DATA_WIDTH-1:0] data, input bit typed,
                         input result_t typed_res);
        result_t predicted;
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_key     <= key;
        s_data_in <= data;
        do @(posedge aclk); while (!s_ready);
        predicted = probe_table(cmd, key, data);
        pending_results.push_back(typed ? typed_res : predicted);
        requests_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    // Sender: reset, directed rows, random phases, then drain and verdict.
    initial begin
        result_t              typed_res;
        logic [KEY_WIDTH-1:0] key;
        logic [CMD_W-1:0]     cmd;
        int                   mode;
        int                   pick;
        int                   i;

        for (i = 0; i < TABLE_DEPTH; i++) begin
            model_keys[i] = KEY_EMPTY;
            model_data[i] = '0;
        end
        // half of the pool lands on slots 0..7 to build long probe chains
        for (i = 0; i < POOL_SIZE; i++) begin
            key = $urandom;
            if (i % 2 == 0) begin
                key[5:0] = 6'($urandom_range(0, 7));
            end
            if (key < 2) begin
                key = key + 64;
            end
            key_pool[i] = key;
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < NUM_ROWS; i++) begin
            typed_res.status = directed_rows[i].status;
            typed_res.data   = directed_rows[i].rdata;
            offer(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].data,
                  directed_rows[i].typed, typed_res);
        end

        typed_res = '0;
        while (requests_sent < NUM_ROWS + RANDOM_REQUESTS) begin
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
                // insert every pool key (more keys than slots, so late inserts report full), then probe it
                for (i = 0; i < POOL_SIZE; i++) begin
                    offer(CMD_INSERT, key_pool[i], $urandom, 1'b0, typed_res);
                end
                repeat (8) begin
                    key = ($urandom_range(0, 1) != 0) ? $urandom
                                                      : key_pool[$urandom_range(0, POOL_SIZE - 1)];
                    offer(CMD_FIND, key, $urandom, 1'b0, typed_res);
                end
            end else if (mode == 1) begin
                for (i = 0; i < POOL_SIZE; i++) begin
                    offer(CMD_DELETE, key_pool[$urandom_range(0, POOL_SIZE - 1)], $urandom,
                          1'b0, typed_res);
                end
            end else begin
                repeat (40) begin
                    pick = $urandom_range(0, 99);
                    key  = ($urandom_range(0, 99) < 85)
                         ? key_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
                    if (pick < 38) begin
                        cmd = CMD_INSERT;
                    end else if (pick < 72) begin
                        cmd = CMD_FIND;
                    end else if (pick < 92) begin
                        cmd = CMD_DELETE;
                    end else if (pick < 95) begin
                        cmd = CMD_UNUSED;
                    end else begin
                        cmd = CMD_W'($urandom_range(0, 3));
                        key = KEY_WIDTH'($urandom_range(0, 1));
                    end
                    offer(cmd, key, $urandom, 1'b0, typed_res);
                end
            end
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Receiver: a stall pattern drawn at random, plus long hold-offs that back the
    // block up into its request channel.
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 256 == 0) begin
            rx_mode <= $urandom_range(0, 3);
        end
        if (rx_cycle == 2500 || rx_cycle == 60000) begin
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= (rx_cycle % 4 == 0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Result checker
    always @(posedge aclk) begin
        result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d data=%h",
                         $time, m_status, m_data_out);
                mismatch_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_status !== exp_res.status) begin
                    $display("%0t: status mismatch expected=%0d actual=%0d",
                             $time, exp_res.status, m_status);
                    mismatch_count++;
                end
                if (m_data_out !== exp_res.data) begin
                    $display("%0t: data_out mismatch expected=%h actual=%h",
                             $time, exp_res.data, m_data_out);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results pending",
                     $time, IDLE_LIMIT, pending_results.size());
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
